/* src/multiset_reading_debouncer_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multiset reading debouncer
// Implication checks clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTISET_READING_DEBOUNCER_DEFINES_SVH
`define MULTISET_READING_DEBOUNCER_DEFINES_SVH

// same-cycle implication
`define MRD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mrd_pkg.sv */
// ----------------------------------------------------------------------------
// mrd_pkg
// Types and constants shared by the multiset reading debouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrd_pkg;

    localparam int MAX_VALUES = 5;
    localparam int VALUE_BITS = 3;
    localparam int LEN_BITS   = 3;
    localparam int TIMER_BITS = 16;
    localparam int NUM_CODES  = 1 << VALUE_BITS;
    localparam int CNT_BITS   = $clog2(MAX_VALUES + 1);

    typedef logic [VALUE_BITS-1:0] t_val;
    typedef logic [LEN_BITS-1:0]   t_len;
    typedef logic [TIMER_BITS-1:0] t_timer;
    typedef logic [CNT_BITS-1:0]   t_cnt;

    localparam logic   MODE_TICK = 1'b0;
    localparam logic   MODE_OBS  = 1'b1;
    localparam t_timer TIMER_MAX = '1;
    localparam t_timer MIN_STABLE_RESET = TIMER_BITS'(1000);

    typedef struct packed {
        t_len                  len;
        t_val [MAX_VALUES-1:0] v;
    } t_hand;

    typedef struct packed {
        logic  accepted;
        t_hand hand;
    } t_result;

endpackage

`default_nettype wire

/* src/mrd_in_if.sv */
// ----------------------------------------------------------------------------
// mrd_in_if
// Input channel: tick or observed hand, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mrd_in_if;
    import mrd_pkg::*;

    logic valid;
    logic ready;
    logic mode;
    t_len hand_len;
    t_val value_0;
    t_val value_1;
    t_val value_2;
    t_val value_3;
    t_val value_4;

    modport source (
        output valid, mode, hand_len, value_0, value_1, value_2, value_3, value_4,
        input  ready
    );

    modport sink (
        input  valid, mode, hand_len, value_0, value_1, value_2, value_3, value_4,
        output ready
    );
endinterface

`default_nettype wire

/* src/mrd_out_if.sv */
// ----------------------------------------------------------------------------
// mrd_out_if
// Result channel: accepted flag and stable hand, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mrd_out_if;
    import mrd_pkg::*;

    logic valid;
    logic ready;
    logic accepted;
    t_len stable_len;
    t_val stable_value_0;
    t_val stable_value_1;
    t_val stable_value_2;
    t_val stable_value_3;
    t_val stable_value_4;

    modport source (
        output valid, accepted, stable_len, stable_value_0, stable_value_1,
               stable_value_2, stable_value_3, stable_value_4,
        input  ready
    );

    modport sink (
        input  valid, accepted, stable_len, stable_value_0, stable_value_1,
               stable_value_2, stable_value_3, stable_value_4,
        output ready
    );
endinterface

`default_nettype wire

/* src/mrd_lane.sv */
// ----------------------------------------------------------------------------
// mrd_lane
// Counts one value code in the valid slots of two hands and compares counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrd_lane (
    input  mrd_pkg::t_val  i_code,
    input  mrd_pkg::t_hand i_a,
    input  mrd_pkg::t_hand i_b,
    output logic           o_eq
);
    import mrd_pkg::*;

    t_cnt cnt_a;
    t_cnt cnt_b;

    always_comb begin
        cnt_a = '0;
        cnt_b = '0;
        for (int i = 0; i < MAX_VALUES; i++) begin
            if ((LEN_BITS'(i) < i_a.len) && (i_a.v[i] == i_code)) begin
                cnt_a = cnt_a + CNT_BITS'(1);
            end
            if ((LEN_BITS'(i) < i_b.len) && (i_b.v[i] == i_code)) begin
                cnt_b = cnt_b + CNT_BITS'(1);
            end
        end
    end

    assign o_eq = (cnt_a == cnt_b);
endmodule

`default_nettype wire

/* src/mrd_match.sv */
// ----------------------------------------------------------------------------
// mrd_match
// Multiset compare: one lane per value code, merged with the length check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrd_match (
    input  mrd_pkg::t_hand i_a,
    input  mrd_pkg::t_hand i_b,
    output logic           o_eq
);
    import mrd_pkg::*;

    logic [NUM_CODES-1:0] lane_eq;

    for (genvar c = 0; c < NUM_CODES; c++) begin : g_lane
        mrd_lane u_lane (
            .i_code (VALUE_BITS'(c)),
            .i_a    (i_a),
            .i_b    (i_b),
            .o_eq   (lane_eq[c])
        );
    end

    assign o_eq = (i_a.len == i_b.len) && (&lane_eq);
endmodule

`default_nettype wire

/* src/mrd_obuf.sv */
// ----------------------------------------------------------------------------
// mrd_obuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrd_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mrd_pkg::t_result  i_data,
    output logic              o_ready,
    mrd_out_if.source         o_out
);
    import mrd_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid && o_out.ready;
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    assign o_out.valid          = r_main_valid;
    assign o_out.accepted       = r_main.accepted;
    assign o_out.stable_len     = r_main.hand.len;
    assign o_out.stable_value_0 = r_main.hand.v[0];
    assign o_out.stable_value_1 = r_main.hand.v[1];
    assign o_out.stable_value_2 = r_main.hand.v[2];
    assign o_out.stable_value_3 = r_main.hand.v[3];
    assign o_out.stable_value_4 = r_main.hand.v[4];
endmodule

`default_nettype wire

/* src/multiset_reading_debouncer.sv */
// ----------------------------------------------------------------------------
// multiset_reading_debouncer
// Debounce filter for an unordered hand of small values.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries items: mode 0 is a time tick, mode 1 an observed hand of
//   hand_len values (lengths above five count as five). A tick advances a
//   saturating 16-bit stability timer and returns nothing. An observation
//   returns one item on o_out: the accepted flag and the accepted hand.
//   i_cfg_we / i_cfg_wdata write min_stable_ticks (reset value 1000).
//   An observation's result is registered in the result buffer and reaches
//   o_out behind earlier results. One item per cycle while i_in.ready is
//   high; the multiset compare runs in eight value-code lanes in parallel.
//   Reset clears candidate, accepted hand, timer and the result buffer.
//   Results sit in a two-entry buffer; i_in.ready drops only when both
//   entries are full, so one more item is taken while a result is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multiset_reading_debouncer_defines.svh"

module multiset_reading_debouncer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  mrd_pkg::t_timer    i_cfg_wdata,
    mrd_in_if.sink             i_in,
    mrd_out_if.source          o_out
);
    import mrd_pkg::*;

    t_timer  r_min_stable;
    t_hand   r_cand;
    t_hand   r_acc;
    t_timer  r_timer;
    t_hand   n_cand;
    t_hand   n_acc;
    t_timer  n_timer;

    t_hand   obs;
    t_len    obs_len;
    t_val [MAX_VALUES-1:0] raw;
    logic    obs_eq;
    logic    cand_eq_acc;
    logic    in_acc;
    logic    push;
    logic    made_new;
    logic    buf_ready;
    t_result result;

    assign raw = {i_in.value_4, i_in.value_3, i_in.value_2, i_in.value_1, i_in.value_0};
    assign obs_len = (i_in.hand_len > LEN_BITS'(MAX_VALUES)) ? LEN_BITS'(MAX_VALUES)
                                                             : i_in.hand_len;

    always_comb begin
        obs.len = obs_len;
        for (int i = 0; i < MAX_VALUES; i++) begin
            obs.v[i] = (LEN_BITS'(i) < obs_len) ? raw[i] : '0;
        end
    end

    mrd_match u_match_obs (
        .i_a  (r_cand),
        .i_b  (obs),
        .o_eq (obs_eq)
    );

    mrd_match u_match_acc (
        .i_a  (r_acc),
        .i_b  (r_cand),
        .o_eq (cand_eq_acc)
    );

    assign in_acc = i_in.valid && i_in.ready;
    assign push   = in_acc && (i_in.mode == MODE_OBS);

    always_comb begin
        n_cand   = r_cand;
        n_acc    = r_acc;
        n_timer  = r_timer;
        made_new = 1'b0;
        if (in_acc) begin
            if (i_in.mode == MODE_TICK) begin
                if (r_timer != TIMER_MAX) begin
                    n_timer = r_timer + TIMER_BITS'(1);
                end
            end else if (!obs_eq) begin
                n_cand  = obs;
                n_timer = '0;
            end else if (r_timer > r_min_stable) begin
                n_timer = '0;
                if (!cand_eq_acc) begin
                    n_acc    = r_cand;
                    made_new = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_stable <= MIN_STABLE_RESET;
            r_cand       <= '0;
            r_acc        <= '0;
            r_timer      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_stable <= i_cfg_wdata;
            end
            r_cand  <= n_cand;
            r_acc   <= n_acc;
            r_timer <= n_timer;
        end
    end

    assign result.accepted = made_new;
    assign result.hand     = n_acc;

    mrd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_ready (buf_ready),
        .o_out   (o_out)
    );

    assign i_in.ready = buf_ready;

    `MRD_ASSERT_NEXT(a_timer_clear, made_new, r_timer == '0, "timer not cleared on accept")
    `MRD_ASSERT_SAME(a_accept_cause, made_new, obs_eq && !cand_eq_acc, "bad accept")
    `MRD_ASSERT_NEXT(a_acc_is_cand, made_new, cand_eq_acc, "accepted hand not candidate")
    `MRD_ASSERT_SAME(a_stall_full, !i_in.ready, o_out.valid, "stall with empty output")
endmodule

`default_nettype wire

/* tb/multiset_reading_debouncer_test.sv */
// ----------------------------------------------------------------------------
// multiset_reading_debouncer_test
// Self-checking bench for the multiset reading debouncer. A directed table
// covers the corner cases, a saturation pass drives the stability timer to
// its top, and random phases at several thresholds send well-formed hand
// sequences mixed with noise. Every result is checked field by field against
// the table or a behavioral predictor, with random gaps and result stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multiset_reading_debouncer_test;
    import mrd_pkg::*;

    localparam int RUN_LIMIT  = 500_000;
    localparam int SAT_TICKS  = 65536;
    localparam int HAND_BITS  = MAX_VALUES * VALUE_BITS;
    localparam int DIR_ROWS   = 27;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic                  mode;
        t_len                  len;
        t_val [MAX_VALUES-1:0] v;
    } t_item;

    typedef struct {
        logic mode;
        int   len;
        int   v [MAX_VALUES];
        int   reps;
        bit   typed;
        bit   eacc;
        int   elen;
        int   ev [MAX_VALUES];
    } t_row;

    logic    clk;
    logic    rst_n;
    logic    cfg_we;
    t_timer  cfg_wdata;

    mrd_in_if  in_if ();
    mrd_out_if out_if ();

    multiset_reading_debouncer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // threshold 2 is in force while the table runs
    t_row dir_rows [DIR_ROWS] = '{
        '{MODE_OBS,  0, '{0, 0, 0, 0, 0}, 1, 1'b1, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_OBS,  5, '{7, 7, 7, 7, 7}, 1, 1'b1, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_TICK, 0, '{0, 0, 0, 0, 0}, 3, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_OBS,  5, '{7, 7, 7, 7, 7}, 1, 1'b1, 1'b1, 5, '{7, 7, 7, 7, 7}},
        '{MODE_OBS,  7, '{7, 7, 7, 7, 7}, 1, 1'b1, 1'b0, 5, '{7, 7, 7, 7, 7}},
        '{MODE_TICK, 7, '{5, 2, 7, 1, 3}, 1, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_OBS,  3, '{1, 2, 3, 6, 5}, 1, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_TICK, 5, '{7, 7, 7, 7, 7}, 4, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_OBS,  3, '{3, 1, 2, 0, 4}, 1, 1'b1, 1'b1, 3, '{1, 2, 3, 0, 0}},
        '{MODE_TICK, 0, '{0, 0, 0, 0, 0}, 3, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_OBS,  3, '{2, 1, 3, 7, 7}, 1, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_OBS,  3, '{1, 1, 2, 5, 5}, 1, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_TICK, 0, '{0, 0, 0, 0, 0}, 3, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_OBS,  3, '{1, 2, 2, 0, 0}, 1, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_TICK, 0, '{0, 0, 0, 0, 0}, 3, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_OBS,  3, '{2, 2, 1, 0, 0}, 1, 1'b1, 1'b1, 3, '{1, 2, 2, 0, 0}},
        '{MODE_OBS,  6, '{4, 3, 0, 6, 1}, 1, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_TICK, 0, '{0, 0, 0, 0, 0}, 3, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_OBS,  5, '{1, 6, 0, 3, 4}, 1, 1'b1, 1'b1, 5, '{4, 3, 0, 6, 1}},
        '{MODE_OBS,  0, '{7, 7, 7, 7, 7}, 1, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_TICK, 0, '{0, 0, 0, 0, 0}, 3, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_OBS,  0, '{1, 2, 3, 4, 5}, 1, 1'b1, 1'b1, 0, '{0, 0, 0, 0, 0}},
        '{MODE_OBS,  1, '{4, 0, 0, 0, 0}, 1, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_TICK, 0, '{0, 0, 0, 0, 0}, 2, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_OBS,  1, '{4, 6, 6, 6, 6}, 1, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_TICK, 0, '{0, 0, 0, 0, 0}, 1, 1'b0, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{MODE_OBS,  1, '{4, 1, 1, 1, 1}, 1, 1'b1, 1'b1, 1, '{4, 0, 0, 0, 0}}
    };

    // predictor state
    t_timer  min_ticks   = MIN_STABLE_RESET;
    t_timer  hold_ticks  = '0;
    t_hand   cand_hand   = '0;
    t_hand   stable_hand = '0;

    t_result pending_hands [$];

    int      errors        = 0;
    int      items_sent    = 0;
    int      hands_seen    = 0;
    int      new_hands     = 0;
    int      results_seen  = 0;
    int      thr_settings  = 0;
    int      cycle_count   = 0;
    int      burst_left    = 0;
    bit      no_gaps       = 1'b0;
    int      stall_pos     = 0;
    logic [15:0] stall_pat = '1;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results pending", cycle_count,
                 pending_hands.size());
        $display("** multiset_reading_debouncer: FAILED **");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        if (errors < MAX_PRINTS)
            $display("mismatch at result %0d: %s", results_seen, what);
        errors++;
    endtask

    function automatic bit same_multiset(input t_hand a, input t_hand b);
        int tally [NUM_CODES];
        foreach (tally[c]) tally[c] = 0;
        if (a.len != b.len) return 1'b0;
        for (int i = 0; i < int'(a.len); i++) begin
            tally[a.v[i]]++;
            tally[b.v[i]]--;
        end
        foreach (tally[c]) begin
            if (tally[c] != 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit debounce_step(input t_item it, output t_result res);
        t_hand seen;
        int    n;
        res = '0;
        if (it.mode == MODE_TICK) begin
            if (hold_ticks != TIMER_MAX) hold_ticks = hold_ticks + 1'b1;
            return 1'b0;
        end
        n = (int'(it.len) > MAX_VALUES) ? MAX_VALUES : int'(it.len);
        seen = '0;
        seen.len = t_len'(n);
        for (int i = 0; i < n; i++) seen.v[i] = it.v[i];
        if (!same_multiset(cand_hand, seen)) begin
            cand_hand  = seen;
            hold_ticks = '0;
        end else if (hold_ticks > min_ticks) begin
            hold_ticks = '0;
            if (!same_multiset(stable_hand, cand_hand)) begin
                stable_hand  = cand_hand;
                res.accepted = 1'b1;
            end
        end
        res.hand = stable_hand;
        return 1'b1;
    endfunction

    function automatic t_item rand_item(input logic mode);
        t_item it;
        it.mode = mode;
        it.len  = t_len'($urandom_range(0, 7));
        it.v    = HAND_BITS'($urandom());
        return it;
    endfunction

    task automatic put_item(input t_item it, input bit typed = 1'b0,
                            input t_result typed_res = '0);
        t_result res;
        int      gap;
        if (!no_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    in_if.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        in_if.valid    <= 1'b1;
        in_if.mode     <= it.mode;
        in_if.hand_len <= it.len;
        in_if.value_0  <= it.v[0];
        in_if.value_1  <= it.v[1];
        in_if.value_2  <= it.v[2];
        in_if.value_3  <= it.v[3];
        in_if.value_4  <= it.v[4];
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        items_sent++;
        if (debounce_step(it, res)) begin
            hands_seen++;
            if (res.accepted) new_hands++;
            pending_hands.push_back(typed ? typed_res : res);
        end
    endtask

    // hold off until the block is idle: nothing pending, last tick absorbed
    task automatic settle();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_hands.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input t_timer thr);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_we    <= 1'b0;
        min_ticks = thr;
        thr_settings++;
    endtask

    task automatic run_phase(input t_timer thr, input int n_items);
        t_item h;
        t_item it;
        t_val  tmp;
        int    stop_at;
        int    top;
        int    n;
        int    j;
        write_threshold(thr);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 9))
                7, 8: put_item(rand_item(MODE_OBS));
                9: put_item(rand_item(MODE_TICK));
                default: begin
                    // well-formed sequence: a hand, then ticks and reordered repeats
                    top = $urandom_range(0, 1) ? 7 : 1;
                    h = rand_item(MODE_OBS);
                    for (int i = 0; i < MAX_VALUES; i++) h.v[i] = t_val'($urandom_range(0, top));
                    put_item(h);
                    repeat ($urandom_range(1, 3)) begin
                        repeat ($urandom_range(0, int'(thr) + 2)) put_item(rand_item(MODE_TICK));
                        it = h;
                        n = (int'(h.len) > MAX_VALUES) ? MAX_VALUES : int'(h.len);
                        for (int i = n - 1; i > 0; i--) begin
                            j = $urandom_range(0, i);
                            tmp = it.v[i];
                            it.v[i] = it.v[j];
                            it.v[j] = tmp;
                        end
                        for (int i = n; i < MAX_VALUES; i++) it.v[i] = t_val'($urandom_range(0, 7));
                        if (n == MAX_VALUES) it.len = t_len'($urandom_range(MAX_VALUES, 7));
                        if ($urandom_range(0, 4) == 0)
                            it.v[$urandom_range(0, MAX_VALUES - 1)] = t_val'($urandom_range(0, 7));
                        put_item(it);
                    end
                end
            endcase
        end
    endtask

    task automatic check_hand();
        t_result want;
        t_val    got_v [MAX_VALUES];
        got_v[0] = out_if.stable_value_0;
        got_v[1] = out_if.stable_value_1;
        got_v[2] = out_if.stable_value_2;
        got_v[3] = out_if.stable_value_3;
        got_v[4] = out_if.stable_value_4;
        if (pending_hands.size() == 0) begin
            flag_mismatch("result item with nothing pending");
        end else begin
            want = pending_hands.pop_front();
            if (out_if.accepted !== want.accepted)
                flag_mismatch($sformatf("accepted got %b want %b",
                                        out_if.accepted, want.accepted));
            if (out_if.stable_len !== want.hand.len)
                flag_mismatch($sformatf("stable_len got %0d want %0d",
                                        out_if.stable_len, want.hand.len));
            for (int i = 0; i < MAX_VALUES; i++) begin
                if (got_v[i] !== want.hand.v[i])
                    flag_mismatch($sformatf("stable_value_%0d got %0d want %0d",
                                            i, got_v[i], want.hand.v[i]));
            end
        end
        results_seen++;
    endtask

    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) check_hand();
        if (stall_pos == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pat = '1;
                1: stall_pat = 16'($urandom());
                2: stall_pat = 16'($urandom()) & 16'($urandom());
                default: stall_pat = 16'($urandom()) | 16'($urandom());
            endcase
        end
        out_if.ready <= stall_pat[stall_pos % 16];
        stall_pos = (stall_pos + 1) % 48;
    end

    initial begin
        t_item   it;
        t_item   sat;
        t_result want;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_if.valid     = 1'b0;
        in_if.mode      = MODE_TICK;
        in_if.hand_len  = '0;
        in_if.value_0   = '0;
        in_if.value_1   = '0;
        in_if.value_2   = '0;
        in_if.value_3   = '0;
        in_if.value_4   = '0;
        out_if.ready    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_threshold(t_timer'(2));
        foreach (dir_rows[r]) begin
            it.mode = dir_rows[r].mode;
            it.len  = t_len'(dir_rows[r].len);
            want.accepted = dir_rows[r].eacc;
            want.hand.len = t_len'(dir_rows[r].elen);
            for (int i = 0; i < MAX_VALUES; i++) begin
                it.v[i] = t_val'(dir_rows[r].v[i]);
                want.hand.v[i] = t_val'(dir_rows[r].ev[i]);
            end
            repeat (dir_rows[r].reps) put_item(it, dir_rows[r].typed, want);
        end

        // drive the timer to its top: no acceptance at the top threshold,
        // acceptance one below it
        write_threshold(TIMER_MAX);
        sat.mode = MODE_OBS;
        sat.len  = t_len'(MAX_VALUES);
        for (int i = 0; i < MAX_VALUES; i++) sat.v[i] = t_val'(i + 2);
        put_item(sat);
        no_gaps = 1'b1;
        repeat (SAT_TICKS) put_item(rand_item(MODE_TICK));
        no_gaps = 1'b0;
        sat.v = {sat.v[0], sat.v[3], sat.v[2], sat.v[1], sat.v[4]};
        put_item(sat);
        write_threshold(TIMER_MAX - 1'b1);
        put_item(sat);

        run_phase(t_timer'(0), 210);
        run_phase(t_timer'(1), 210);
        run_phase(t_timer'(3), 210);
        run_phase(t_timer'($urandom_range(2, 6)), 210);
        run_phase(t_timer'(0), 210);
        settle();

        $display("sent %0d items: %0d observed hands, %0d new stable hands, %0d thresholds",
                 items_sent, hands_seen, new_hands, thr_settings);
        $display("checked %0d result items, %0d mismatches", results_seen, errors);
        if (errors == 0) begin
            $display("** multiset_reading_debouncer: PASSED **");
        end else begin
            $display("** multiset_reading_debouncer: FAILED **");
        end
        $finish;
    end

endmodule
